// ----- rtl/core/cwsum_pkg.sv -----
// ----------------------------------------------------------------------------
// cwsum_pkg
// Shared types and fixed constants of the column window sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package cwsum_pkg;

    localparam int unsigned ROWS_W   = 6;
    localparam int unsigned ROWS_MAX = 63;
    localparam int unsigned CFG_W    = 4;
    localparam int unsigned CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS_BEFORE = 1'b0,
        REG_RADIUS_AFTER  = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/core/cwsum_in_if.sv -----
// ----------------------------------------------------------------------------
// cwsum_in_if
// Input channel: one sample word with its end-of-column mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface cwsum_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_in_column;

    modport source (output valid, output sample, output last_in_column, input ready);
    modport sink   (input valid, input sample, input last_in_column, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cwsum_out_if.sv -----
// ----------------------------------------------------------------------------
// cwsum_out_if
// Output channel: one window sum word with its flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface cwsum_out_if #(
    parameter int SUM_BITS = 21
);
    logic                       valid;
    logic                       ready;
    logic signed [SUM_BITS-1:0] window_sum;
    logic                       end_of_column;
    logic                       last_of_run;

    modport source (output valid, output window_sum, output end_of_column,
                    output last_of_run, input ready);
    modport sink   (input valid, input window_sum, input end_of_column,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/column_window_sum.sv -----
// ----------------------------------------------------------------------------
// column_window_sum
// Clipped box sum down one column, each window summed from a history RAM.
// ----------------------------------------------------------------------------
// Each result walks back from the newest sample through far+1 RAM entries
// (far = distance of the row plus its upper extent), one read a cycle; an
// unmarked sample gives at most one result, the end-of-column sample up to
// radius_after+1. A new sample is taken once the last sum is in the output
// register. Reset (synchronous, active low) clears the counters and sets
// both radii to one; the RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module column_window_sum #(
    parameter int MAX_RADIUS    = 15,
    parameter int HISTORY_DEPTH = 32,
    parameter int SAMPLE_BITS   = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [cwsum_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [cwsum_pkg::CFG_W-1:0]    i_cfg_data,
    cwsum_in_if.sink                            i_in,
    cwsum_out_if.source                         o_out
);

    localparam int AW       = $clog2(HISTORY_DEPTH);
    localparam int RW       = cwsum_pkg::ROWS_W;
    localparam int SUM_BITS = SAMPLE_BITS + $clog2(2 * MAX_RADIUS + 1);

    cwsum_pkg::t_state r_state, n_state;

    logic [cwsum_pkg::CFG_W-1:0] r_radius_before, r_radius_after;
    logic [RW-1:0]  r_rows, r_last, r_d, r_near, r_far, r_e;
    logic           r_marked;
    logic [AW-1:0]  r_wslot, r_newest, r_ptr;
    logic           r_pend_valid, r_pend_use;
    logic signed [SUM_BITS-1:0] r_acc;

    logic signed [SUM_BITS-1:0] r_out_sum;
    logic           r_out_valid, r_out_eoc, r_out_last;

    logic [RW-1:0]  rb, ra, rows_new, last, first, up, down, row;
    logic           accept, marked, go, out_free, more;
    logic [SAMPLE_BITS-1:0] rd_data;

    // clamped radii
    assign rb = ({2'b00, r_radius_before} > RW'(MAX_RADIUS)) ? RW'(MAX_RADIUS)
                                                            : {2'b00, r_radius_before};
    assign ra = ({2'b00, r_radius_after} > RW'(MAX_RADIUS)) ? RW'(MAX_RADIUS)
                                                           : {2'b00, r_radius_after};

    assign accept   = i_in.valid && i_in.ready;
    assign marked   = i_in.last_in_column;
    assign rows_new = (r_rows == RW'(cwsum_pkg::ROWS_MAX)) ? r_rows : r_rows + RW'(1);
    assign last     = rows_new - RW'(1);
    assign first    = (marked && (last < ra)) ? last : ra;
    assign go       = marked || (last >= ra);

    // window extents of the current row
    assign row  = r_last - r_d;
    assign up   = (row < rb) ? row : rb;
    assign down = (r_d < ra) ? r_d : ra;

    assign out_free = !r_out_valid || o_out.ready;
    assign more     = r_marked && (r_d != '0);

    cwsum_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_wslot),
        .i_wdata (i_in.sample),
        .i_raddr (r_ptr),
        .o_rdata (rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cwsum_pkg::ST_IDLE: begin
                if (accept && go) begin
                    n_state = cwsum_pkg::ST_START;
                end
            end
            cwsum_pkg::ST_START: n_state = cwsum_pkg::ST_READ;
            cwsum_pkg::ST_READ: begin
                if (r_e == r_far) begin
                    n_state = cwsum_pkg::ST_DRAIN;
                end
            end
            cwsum_pkg::ST_DRAIN: n_state = cwsum_pkg::ST_DONE;
            cwsum_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = more ? cwsum_pkg::ST_START : cwsum_pkg::ST_IDLE;
                end
            end
            default: n_state = cwsum_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_in.ready         = (r_state == cwsum_pkg::ST_IDLE);
        o_out.valid        = r_out_valid;
        o_out.window_sum   = r_out_sum;
        o_out.end_of_column = r_out_eoc;
        o_out.last_of_run  = r_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= cwsum_pkg::ST_IDLE;
            r_radius_before <= cwsum_pkg::CFG_W'(1);
            r_radius_after  <= cwsum_pkg::CFG_W'(1);
            r_rows          <= '0;
            r_wslot         <= '0;
            r_pend_valid    <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (cwsum_pkg::t_cfg_reg'(i_cfg_index))
                    cwsum_pkg::REG_RADIUS_BEFORE: r_radius_before <= i_cfg_data;
                    cwsum_pkg::REG_RADIUS_AFTER:  r_radius_after  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (accept) begin
                r_rows  <= marked ? '0 : rows_new;
                r_wslot <= (r_wslot == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wslot + AW'(1);
            end

            r_pend_valid <= (r_state == cwsum_pkg::ST_READ);

            if (r_state == cwsum_pkg::ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_last   <= last;
            r_marked <= marked;
            r_d      <= first;
            r_newest <= r_wslot;
        end

        if (r_state == cwsum_pkg::ST_START) begin
            r_near <= r_d - down;
            r_far  <= r_d + up;
            r_e    <= '0;
            r_ptr  <= r_newest;
            r_acc  <= '0;
        end

        if (r_state == cwsum_pkg::ST_READ) begin
            r_pend_use <= (r_e >= r_near);
            r_e        <= r_e + RW'(1);
            r_ptr      <= (r_ptr == '0) ? AW'(HISTORY_DEPTH - 1) : r_ptr - AW'(1);
        end

        // sign-extend and accumulate the word read in the previous cycle
        if (r_pend_valid && r_pend_use) begin
            r_acc <= r_acc + SUM_BITS'(signed'(rd_data));
        end

        if (r_state == cwsum_pkg::ST_DONE && out_free) begin
            r_out_sum  <= r_acc;
            r_out_eoc  <= r_marked && (r_d == '0);
            r_out_last <= !r_marked || (r_d == '0);
            if (more) begin
                r_d <= r_d - RW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/cwsum_ram.sv -----
// ----------------------------------------------------------------------------
// cwsum_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cwsum_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
